>>> rtl/isbn_pkg.sv
`timescale 1ns / 1ps
// isbn_pkg: shared types and constants for the hyphenated ISBN-13 validator.
// Holds the status codes, the scan state record and character constants.
// No dependencies.
package isbn_pkg;

    // Status codes, first failing check wins
    typedef enum logic [3:0] {
        ST_VALID         = 4'd0,
        ST_BAD_CHAR      = 4'd1,
        ST_DOUBLE_HYPHEN = 4'd2,
        ST_LEAD_HYPHEN   = 4'd3,
        ST_TRAIL_HYPHEN  = 4'd4,
        ST_HYPHEN_COUNT  = 4'd5,
        ST_TOO_FEW       = 4'd6,
        ST_TOO_MANY      = 4'd7,
        ST_PREFIX        = 4'd8,
        ST_GROUP         = 4'd9,
        ST_REGISTRANT    = 4'd10,
        ST_PUBLICATION   = 4'd11,
        ST_CHECK_LEN     = 4'd12,
        ST_CHECKSUM      = 4'd13
    } status_t;

    // Character codes
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

    // Limits
    localparam logic [9:0] PREFIX_978    = 10'd978;
    localparam logic [9:0] PREFIX_979    = 10'd979;
    localparam logic [9:0] PREFIX_SAT    = 10'd1023;
    localparam logic [4:0] ISBN_DIGITS   = 5'd13;
    localparam logic [3:0] GROUP_MAX     = 4'd5;
    localparam logic [3:0] REGISTRANT_MAX = 4'd7;
    localparam logic [3:0] PUB_MAX       = 4'd6;
    localparam logic [3:0] CHECK_MAX     = 4'd1;
    localparam logic [2:0] HYPHENS_REQ   = 3'd4;

    // Element indexes
    localparam logic [2:0] ELEM_PREFIX     = 3'd0;
    localparam logic [2:0] ELEM_GROUP      = 3'd1;
    localparam logic [2:0] ELEM_REGISTRANT = 3'd2;
    localparam logic [2:0] ELEM_PUB        = 3'd3;
    localparam logic [2:0] ELEM_CHECK      = 3'd4;

    // Fault flag bits
    localparam int FLAG_GROUP      = 0;
    localparam int FLAG_REGISTRANT = 1;
    localparam int FLAG_PUB        = 2;
    localparam int FLAG_CHECK      = 3;

    // Scan state carried from character to character
    typedef struct packed {
        logic [4:0] digit_total;
        logic [2:0] hyphen_total;
        logic       bad_char_seen;
        logic       double_hyphen_seen;
        logic       at_first_char;
        logic       prev_hyphen;
        logic [2:0] element_index;
        logic [3:0] element_sig_digits;
        logic       element_nonzero_seen;
        logic       element_digit_seen;
        logic [9:0] prefix_value;
        logic [3:0] length_fault_flags;
        logic       leading_hyphen_seen;
        logic [3:0] weighted_sum_mod10;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        digit_total:          5'd0,
        hyphen_total:         3'd0,
        bad_char_seen:        1'b0,
        double_hyphen_seen:   1'b0,
        at_first_char:        1'b1,
        prev_hyphen:          1'b0,
        element_index:        3'd0,
        element_sig_digits:   4'd0,
        element_nonzero_seen: 1'b0,
        element_digit_seen:   1'b0,
        prefix_value:         10'd0,
        length_fault_flags:   4'd0,
        leading_hyphen_seen:  1'b0,
        weighted_sum_mod10:   4'd0
    };

endpackage

>>> rtl/isbn13_hyphenated_validator.sv
`timescale 1ns / 1ps
// isbn13_hyphenated_validator: top level, input and result registers.
// Depends on isbn_pkg and isbn_scan.
//
// Usage: send a hyphenated ISBN-13 one character per request on the input
// channel (in_valid/in_ready, char_code, last_char). Set last_char on the
// final character. One status request leaves on the output channel
// (out_valid/out_ready, status) for each string; other characters give none.
// A status comes from the result register; the input register holds the last
// character while the scan logic judges it, and the result register captures
// the status as the character advances. Throughput: one character per cycle
// unless a last character waits on a full result register. The scan state
// is updated by one pass of narrow counter and flag logic per character.
// Reset clears the scan state and the valid flags of the input and result
// registers; the first character after reset starts a new string.
// When the receiver stalls, the pending status stays in the result register;
// characters without last_char still flow. A last character then waits in
// the input register with in_ready low until the result register frees.
module isbn13_hyphenated_validator
    import isbn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] status
);

    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       out_valid_reg;
    logic [3:0] status_reg;
    logic       out_free;
    logic       advance;
    status_t    scan_status;

    // Handshake: advance the held character when its result can be stored
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign in_ready = !in_valid_reg || advance;

    // Input register, control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // Input register, payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
            last_reg <= last_char;
        end
    end

    isbn_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_code (char_reg),
        .last_char (last_reg),
        .status    (scan_status)
    );

    // Result register, control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result register, payload
    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
            status_reg <= scan_status;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

endmodule

>>> rtl/isbn_scan.sv
`timescale 1ns / 1ps
// isbn_scan: per-character scan state and the final status decision.
// Depends on isbn_pkg.
module isbn_scan
    import isbn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output status_t    status
);

    scan_state_t scan_reg;
    scan_state_t scan_next;

    // Reduce a value below 40 to mod 10
    function automatic logic [3:0] mod10_small(input logic [5:0] v);
        logic [5:0] r;
        begin
            if (v >= 6'd30)
                r = v - 6'd30;
            else if (v >= 6'd20)
                r = v - 6'd20;
            else if (v >= 6'd10)
                r = v - 6'd10;
            else
                r = v;
            return r[3:0];
        end
    endfunction

    // Close the current element: check its length, move to the next one
    function automatic scan_state_t close_element(input scan_state_t s);
        scan_state_t o;
        logic [3:0]  len;
        begin
            o = s;
            if (s.element_nonzero_seen)
                len = s.element_sig_digits;
            else
                len = s.element_digit_seen ? 4'd1 : 4'd0;
            if (s.element_index == ELEM_GROUP && len > GROUP_MAX)
                o.length_fault_flags[FLAG_GROUP] = 1'b1;
            if (s.element_index == ELEM_REGISTRANT && len > REGISTRANT_MAX)
                o.length_fault_flags[FLAG_REGISTRANT] = 1'b1;
            if (s.element_index == ELEM_PUB && len > PUB_MAX)
                o.length_fault_flags[FLAG_PUB] = 1'b1;
            if (s.element_index == ELEM_CHECK && len > CHECK_MAX)
                o.length_fault_flags[FLAG_CHECK] = 1'b1;
            if (s.element_index != 3'd7)
                o.element_index = s.element_index + 3'd1;
            o.element_sig_digits   = 4'd0;
            o.element_nonzero_seen = 1'b0;
            o.element_digit_seen   = 1'b0;
            return o;
        end
    endfunction

    logic        is_digit;
    logic        is_hyphen;
    logic [3:0]  digit;
    logic [5:0]  weighted;
    logic [13:0] prefix_mult;
    scan_state_t upd;

    // Character update, then close and judge on the last character
    always_comb
    begin
        is_digit    = char_code inside {[CHAR_0:CHAR_9]};
        is_hyphen   = (char_code == CHAR_HYPHEN);
        digit       = char_code[3:0];
        weighted    = scan_reg.digit_total[0]
                    ? ({1'b0, digit, 1'b0} + {2'd0, digit})
                    : {2'd0, digit};
        prefix_mult = ({4'd0, scan_reg.prefix_value} << 3)
                    + ({4'd0, scan_reg.prefix_value} << 1)
                    + {10'd0, digit};
        upd = scan_reg;

        if (is_digit)
        begin
            upd.weighted_sum_mod10 =
                mod10_small({2'd0, scan_reg.weighted_sum_mod10} + weighted);
            if (scan_reg.digit_total != 5'd31)
                upd.digit_total = scan_reg.digit_total + 5'd1;
            if (scan_reg.element_index == ELEM_PREFIX)
                upd.prefix_value = (prefix_mult > {4'd0, PREFIX_SAT})
                                 ? PREFIX_SAT : prefix_mult[9:0];
            if (digit != 4'd0 || scan_reg.element_nonzero_seen)
            begin
                if (scan_reg.element_sig_digits != 4'd15)
                    upd.element_sig_digits = scan_reg.element_sig_digits + 4'd1;
                upd.element_nonzero_seen = 1'b1;
            end
            upd.element_digit_seen = 1'b1;
        end
        else if (is_hyphen)
        begin
            if (scan_reg.hyphen_total != 3'd7)
                upd.hyphen_total = scan_reg.hyphen_total + 3'd1;
            if (scan_reg.prev_hyphen)
                upd.double_hyphen_seen = 1'b1;
            if (scan_reg.at_first_char)
                upd.leading_hyphen_seen = 1'b1;
            upd = close_element(upd);
        end
        else
        begin
            upd.bad_char_seen = 1'b1;
        end
        upd.prev_hyphen   = is_hyphen;
        upd.at_first_char = 1'b0;

        // final element closes at end of string unless a hyphen just did
        if (last_char && !is_hyphen)
            upd = close_element(upd);

        // status, first failing check wins
        if (upd.bad_char_seen)
            status = ST_BAD_CHAR;
        else if (upd.double_hyphen_seen)
            status = ST_DOUBLE_HYPHEN;
        else if (upd.leading_hyphen_seen)
            status = ST_LEAD_HYPHEN;
        else if (is_hyphen)
            status = ST_TRAIL_HYPHEN;
        else if (upd.hyphen_total != HYPHENS_REQ)
            status = ST_HYPHEN_COUNT;
        else if (upd.digit_total < ISBN_DIGITS)
            status = ST_TOO_FEW;
        else if (upd.digit_total > ISBN_DIGITS)
            status = ST_TOO_MANY;
        else if (upd.prefix_value != PREFIX_978 && upd.prefix_value != PREFIX_979)
            status = ST_PREFIX;
        else if (upd.length_fault_flags[FLAG_GROUP])
            status = ST_GROUP;
        else if (upd.length_fault_flags[FLAG_REGISTRANT])
            status = ST_REGISTRANT;
        else if (upd.length_fault_flags[FLAG_PUB])
            status = ST_PUBLICATION;
        else if (upd.length_fault_flags[FLAG_CHECK])
            status = ST_CHECK_LEN;
        else if (upd.weighted_sum_mod10 != 4'd0)
            status = ST_CHECKSUM;
        else
            status = ST_VALID;

        // next string starts from a clean state
        if (!step)
            scan_next = scan_reg;
        else if (last_char)
            scan_next = SCAN_RESET;
        else
            scan_next = upd;
    end

    // Scan state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_reg <= SCAN_RESET;
        else
            scan_reg <= scan_next;
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for the hyphenated ISBN-13 validator.
// Streams directed and random character strings through the request channels
// and checks each status against a local scan predictor. Depends on isbn_pkg.
module tb_top;
    import isbn_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // One character request; drain holds it back until all statuses are in
    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       drain;
    } char_req_t;

    // Predictor copy of the per-string scan state
    typedef struct packed {
        logic [4:0] digits;
        logic [2:0] hyphens;
        logic       bad;
        logic       dbl;
        logic       first;
        logic       prev_hy;
        logic       lead;
        logic [2:0] elem;
        logic [3:0] sig;
        logic       nonzero;
        logic       has_digit;
        logic [9:0] prefix;
        logic [3:0] faults;
        logic [3:0] sum;
    } scan_t;

    localparam scan_t SCAN_IDLE = '{first: 1'b1, default: '0};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] char_code = '0;
    logic       last_char = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [3:0] status;

    char_req_t pending_chars[$];
    status_t   expected_status[$];
    scan_t     sc = SCAN_IDLE;
    int        fail_count = 0;
    int        chars_queued = 0;
    int        burst_left = 1;
    int        gap_left = 0;
    int        rx_cycle = 0;

    isbn13_hyphenated_validator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Close the current element and record a length fault for it
    task automatic close_field();
        int flen;
        if (sc.nonzero)
            flen = sc.sig;
        else
            flen = sc.has_digit ? 1 : 0;
        case (sc.elem)
            ELEM_GROUP:      if (flen > GROUP_MAX)      sc.faults[FLAG_GROUP] = 1'b1;
            ELEM_REGISTRANT: if (flen > REGISTRANT_MAX) sc.faults[FLAG_REGISTRANT] = 1'b1;
            ELEM_PUB:        if (flen > PUB_MAX)        sc.faults[FLAG_PUB] = 1'b1;
            ELEM_CHECK:      if (flen > CHECK_MAX)      sc.faults[FLAG_CHECK] = 1'b1;
            default: ;
        endcase
        if (sc.elem != 3'd7)
            sc.elem++;
        sc.sig       = '0;
        sc.nonzero   = 1'b0;
        sc.has_digit = 1'b0;
    endtask

    // Advance the scan by one accepted character; on the last one, queue its status
    task automatic scan_char(input logic [7:0] c, input logic last);
        int      d;
        int      p;
        logic    hy;
        status_t st;
        hy = (c == CHAR_HYPHEN);
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            d = c - CHAR_0;
            sc.sum = 4'((sc.sum + (sc.digits[0] ? 3 : 1) * d) % 10);
            if (sc.digits != 5'd31)
                sc.digits++;
            if (sc.elem == ELEM_PREFIX)
            begin
                p = sc.prefix * 10 + d;
                sc.prefix = (p > PREFIX_SAT) ? PREFIX_SAT : 10'(p);
            end
            if (d != 0 || sc.nonzero)
            begin
                if (sc.sig != 4'd15)
                    sc.sig++;
                sc.nonzero = 1'b1;
            end
            sc.has_digit = 1'b1;
        end
        else if (hy)
        begin
            if (sc.hyphens != 3'd7)
                sc.hyphens++;
            if (sc.prev_hy)
                sc.dbl = 1'b1;
            if (sc.first)
                sc.lead = 1'b1;
            close_field();
        end
        else
            sc.bad = 1'b1;
        sc.prev_hy = hy;
        sc.first   = 1'b0;

        if (last)
        begin
            if (!hy)
                close_field();
            if (sc.bad)                                  st = ST_BAD_CHAR;
            else if (sc.dbl)                             st = ST_DOUBLE_HYPHEN;
            else if (sc.lead)                            st = ST_LEAD_HYPHEN;
            else if (hy)                                 st = ST_TRAIL_HYPHEN;
            else if (sc.hyphens != HYPHENS_REQ)          st = ST_HYPHEN_COUNT;
            else if (sc.digits < ISBN_DIGITS)            st = ST_TOO_FEW;
            else if (sc.digits > ISBN_DIGITS)            st = ST_TOO_MANY;
            else if (sc.prefix != PREFIX_978 && sc.prefix != PREFIX_979)
                                                         st = ST_PREFIX;
            else if (sc.faults[FLAG_GROUP])              st = ST_GROUP;
            else if (sc.faults[FLAG_REGISTRANT])         st = ST_REGISTRANT;
            else if (sc.faults[FLAG_PUB])                st = ST_PUBLICATION;
            else if (sc.faults[FLAG_CHECK])              st = ST_CHECK_LEN;
            else if (sc.sum != 4'd0)                     st = ST_CHECKSUM;
            else                                         st = ST_VALID;
            expected_status.push_back(st);
            sc = SCAN_IDLE;
        end
    endtask

    // Queue one string of characters, last flag on the final one
    task automatic add_bytes(input byte_q_t s, input logic drain);
        char_req_t r;
        for (int i = 0; i < s.size(); i++)
        begin
            r.code  = s[i];
            r.last  = (i == s.size() - 1);
            r.drain = drain && (i == 0);
            pending_chars.push_back(r);
        end
        chars_queued += s.size();
    endtask

    task automatic add_string(input string txt, input logic drain);
        byte_q_t s;
        for (int i = 0; i < txt.len(); i++)
            s.push_back(txt[i]);
        add_bytes(s, drain);
    endtask

    // Well-formed ISBN with random content and element split, sometimes damaged
    task automatic add_random_isbn();
        logic [3:0] dig[13];
        byte_q_t    s;
        int         g;
        int         r;
        int         cl;
        int         n;
        int         acc;
        int         pos;
        dig[0] = 4'd9;
        dig[1] = 4'd7;
        dig[2] = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 9))
                                             : 4'($urandom_range(8, 9));
        for (int k = 3; k < 12; k++)
            dig[k] = 4'($urandom_range(0, 9));
        cl = ($urandom_range(0, 9) == 0) ? 2 : 1;
        n  = 10 - cl;
        g  = ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(1, 5);
        r  = $urandom_range(1, n - 1 - g);
        if (r > 7)
            r = 7;
        // leading zeros in group or registrant
        if ($urandom_range(0, 3) == 0)
            dig[3 + g] = 4'd0;
        if ($urandom_range(0, 5) == 0)
            dig[3] = 4'd0;
        acc = 0;
        for (int k = 0; k < 12; k++)
            acc += dig[k] * ((k % 2) ? 3 : 1);
        dig[12] = 4'((10 - acc % 10) % 10);
        for (int k = 0; k < 13; k++)
        begin
            if (k == 3 || k == 3 + g || k == 3 + g + r || k == 13 - cl)
                s.push_back(CHAR_HYPHEN);
            s.push_back(8'(CHAR_0 + dig[k]));
        end

        if ($urandom_range(0, 2) == 0)
        begin
            pos = $urandom_range(0, s.size() - 1);
            case ($urandom_range(0, 3))
                0: s[pos] = 8'($urandom_range(0, 255));
                1: if (s[pos] != CHAR_HYPHEN) s[pos] = 8'(CHAR_0 + $urandom_range(0, 9));
                2: s.insert(pos, CHAR_HYPHEN);
                default: s.delete(pos);
            endcase
        end
        add_bytes(s, $urandom_range(0, 9) == 0);
    endtask

    // Short noise string of digits, hyphens and arbitrary codes
    task automatic add_random_noise();
        byte_q_t s;
        int      n;
        n = $urandom_range(1, 24);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: s.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
                5, 6:          s.push_back(CHAR_HYPHEN);
                default:       s.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        add_bytes(s, 1'b0);
    endtask

    // Request driver: bursts of characters with random gaps
    always @(posedge clk or negedge rst_n)
    begin : driver
        char_req_t nxt;
        logic      hold;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            char_code  <= '0;
            last_char  <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            hold = in_valid;
            if (in_valid && in_ready)
            begin
                scan_char(char_code, last_char);
                hold = 1'b0;
            end
            if (!hold)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_chars.size() != 0 &&
                         (!pending_chars[0].drain || expected_status.size() == 0))
                begin
                    nxt = pending_chars.pop_front();
                    in_valid  <= 1'b1;
                    char_code <= nxt.code;
                    last_char <= nxt.last;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        if ($urandom_range(0, 2) == 0)
                            gap_left = 0;
                        else if ($urandom_range(0, 7) == 0)
                            gap_left = 24;
                        else
                            gap_left = $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: rotating stall patterns plus a long hold-off window
    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_cycle  <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if ((rx_cycle % 1600) >= 500 && (rx_cycle % 1600) < 800)
                out_ready <= 1'b0;
            else
            begin
                case (rx_cycle[8:7])
                    2'd0:    out_ready <= 1'b1;
                    2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
                    2'd2:    out_ready <= (rx_cycle[1:0] == 2'b00);
                    default: out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Status checker
    always @(posedge clk)
    begin : monitor
        status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status.size() == 0)
            begin
                $error("status: expected none, actual %0d", status);
                fail_count++;
            end
            else
            begin
                want = expected_status.pop_front();
                if (status !== want)
                begin
                    $error("status: expected %0d (%s), actual %0d", want, want.name(), status);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        byte_q_t s;

        // directed strings: every status but ST_REGISTRANT, and the saturation corners
        add_string("978-0-306-40615-7", 1'b0);
        add_string("979-10-90636-07-1", 1'b1);
        s = '{8'h00, 8'h2F, 8'h3A, 8'h2C, 8'h80, 8'hFF, 8'h20, 8'h7F};
        add_bytes(s, 1'b0);
        add_string("1--2", 1'b0);
        add_string("-978-0-306-40615-7", 1'b0);
        add_string("978-0-306-40615-", 1'b0);
        add_string("0", 1'b0);
        add_string("-", 1'b0);
        add_string("978-0-306-4061-5", 1'b0);
        add_string("978-0-306-406155-7", 1'b0);
        add_string("977-0-306-40615-7", 1'b0);
        add_string("978-123456-12-1-1", 1'b0);
        add_string("978-1-1-1234567-1", 1'b0);
        add_string("978-1-1-123456-12", 1'b0);
        add_string("978-0-306-40615-8", 1'b1);
        add_string("0978-0-306-4061-2", 1'b0);
        add_string("978-0000001-1-1-5", 1'b0);
        add_string("978-0-306-40615-0", 1'b0);
        add_string("9780-306-4-615-7", 1'b0);
        add_string("1-1-1-1-1-1-1-1-1-1", 1'b0);
        s.delete();
        repeat (35)
            s.push_back(8'(CHAR_0 + 9));
        add_bytes(s, 1'b0);

        // random strings, mostly well-formed
        while (chars_queued < 1050)
        begin
            if ($urandom_range(0, 3) == 0)
                add_random_noise();
            else
                add_random_isbn();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
